FILE: hw/rtl/dqap_pkg.sv
`timescale 1ns / 1ps

package dqap_pkg;

	// Character codes of the address text.
	localparam logic [7:0] CH_END  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Part limits and dot limit.
	localparam logic [8:0] PART_MAX = 9'd255;
	localparam logic [8:0] PART_SAT = 9'd256;
	localparam logic [1:0] MAX_DOTS = 2'd3;

	// Class of one incoming character.
	typedef enum logic [1:0] {
		CLS_END,
		CLS_DIGIT,
		CLS_DOT,
		CLS_OTHER
	} char_class_t;

	// One result word as it travels from the parse core to the output stage.
	typedef struct packed {
		logic        parse_ok;
		logic [31:0] address;
	} result_t;

	// Sort a character into its class.
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		if (c == CH_END) begin
			cls = CLS_END;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			cls = CLS_DIGIT;
		end else if (c == CH_DOT) begin
			cls = CLS_DOT;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

endpackage

FILE: hw/rtl/dqap_in_stage.sv
`timescale 1ns / 1ps

module dqap_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] char_s1
);
	import dqap_pkg::*;

	// The register may load whenever it is empty or its word moves on this cycle.
	assign in_ready = !valid_s1 || take;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Character held for the parse core.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

endmodule

FILE: hw/rtl/dqap_parse_core.sv
`timescale 1ns / 1ps

module dqap_parse_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [7:0]        char_s1,
	input  logic              out_free,
	output logic              take,
	output logic              res_valid,
	output dqap_pkg::result_t res
);
	import dqap_pkg::*;

	logic [8:0]  part_q;
	logic [31:0] asm_q;
	logic [1:0]  dots_q;
	logic        err_q;

	logic [8:0]  part_d;
	logic [31:0] asm_d;
	logic [1:0]  dots_d;
	logic        err_d;

	char_class_t cls;
	logic [12:0] times_ten;
	logic [12:0] digit_sum;
	logic [31:0] full_addr;
	logic        part_big;

	assign cls = classify(char_s1);

	// A terminator can only move on when the output register can take its result.
	assign take      = valid_s1 && (cls != CLS_END || out_free);
	assign res_valid = take && cls == CLS_END;

	// Decimal accumulation: part times ten as two shifts, then the new digit.
	assign times_ten = {1'b0, part_q, 3'b000} + {3'b000, part_q, 1'b0};
	assign digit_sum = times_ten + {9'd0, char_s1[3:0] - CH_ZERO[3:0]};
	assign part_big  = part_q > PART_MAX;
	assign full_addr = {asm_q[23:0], part_q[7:0]};

	// Next state and result for the character in the input register.
	always_comb begin
		part_d  = part_q;
		asm_d   = asm_q;
		dots_d  = dots_q;
		err_d   = err_q;
		res     = '0;
		unique case (cls)
			CLS_END: begin
				if (!err_q && !part_big) begin
					res.parse_ok = 1'b1;
					unique case (dots_q)
						2'd0: res.address = full_addr << 24;
						2'd1: res.address = full_addr << 16;
						2'd2: res.address = full_addr << 8;
						2'd3: res.address = full_addr;
						default: res.address = full_addr;
					endcase
				end
				part_d = '0;
				asm_d  = '0;
				dots_d = '0;
				err_d  = 1'b0;
			end
			CLS_DIGIT: begin
				if (!err_q) begin
					part_d = (digit_sum > {4'd0, PART_SAT}) ? PART_SAT : digit_sum[8:0];
				end
			end
			CLS_DOT: begin
				if (!err_q) begin
					if (dots_q == MAX_DOTS) begin
						err_d = 1'b1;
					end else begin
						dots_d = dots_q + 2'd1;
						if (part_big) begin
							err_d = 1'b1;
						end else begin
							asm_d  = full_addr;
							part_d = '0;
						end
					end
				end
			end
			CLS_OTHER: begin
				err_d = 1'b1;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	// Parse state, updated once for every character that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			asm_q  <= '0;
			dots_q <= '0;
			err_q  <= 1'b0;
		end else if (take) begin
			part_q <= part_d;
			asm_q  <= asm_d;
			dots_q <= dots_d;
			err_q  <= err_d;
		end
	end

endmodule

FILE: hw/rtl/dqap_out_stage.sv
`timescale 1ns / 1ps

module dqap_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  dqap_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              parse_ok,
	output logic [31:0]       address
);
	import dqap_pkg::*;

	result_t res_q;

	// The register is free when empty or when its word is taken this cycle.
	assign out_free = !out_valid || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= res_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

	assign parse_ok = res_q.parse_ok;
	assign address  = res_q.address;

endmodule

FILE: hw/rtl/dotted_quad_address_parser.sv
`timescale 1ns / 1ps
// A terminator word passes from the input register through the parse core into the result
// register, which takes it only when free.
// Throughput: one character word per cycle, set by the parse core, unless input is held back.
// Input is held back only while a terminator waits for a full result register.
// Reset: arst_n clears the parse state and both valid flags asynchronously.
// After each result the parse state returns to its reset value.
module dotted_quad_address_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        parse_ok,
	output logic [31:0] address
);
	import dqap_pkg::*;

	logic       take;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_free;
	logic       res_valid;
	result_t    res;

	// Input register.
	dqap_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.take      (take),
		.valid_s1  (valid_s1),
		.char_s1   (char_s1)
	);

	// Parse state and per-character logic.
	dqap_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.char_s1   (char_s1),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	dqap_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.parse_ok  (parse_ok),
		.address   (address)
	);

endmodule

FILE: hw/rtl/dqap_checker.sv
`timescale 1ns / 1ps

module dqap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  char_code,
	input logic        out_valid,
	input logic        out_ready,
	input logic        parse_ok,
	input logic [31:0] address
);
	import dqap_pkg::*;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parse_ok) && $stable(address))
		else $error("result word changed while stalled");

	// A failed parse always reports address zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> address == 32'd0)
		else $error("failed parse with non-zero address");

	// Input is only held back by a pending result word.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// No result is shown in the cycle after reset has been seen.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

	// A non-terminator word accepted on an idle output cannot produce a result as it passes through the parse core.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && char_code != CH_END && !out_valid ##1 !out_valid
		|=> !out_valid)
		else $error("result without a terminator");

endmodule

bind dotted_quad_address_parser dqap_checker u_dqap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.char_code (char_code),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.parse_ok  (parse_ok),
	.address   (address)
);
